FILE: rtl/reverse_cuthill_mckee_order_core_macros.svh
// Assertion macros shared by the ordering core.
`ifndef REVERSE_CUTHILL_MCKEE_ORDER_CORE_MACROS_SVH
`define REVERSE_CUTHILL_MCKEE_ORDER_CORE_MACROS_SVH

// The condition holds at every clock edge out of reset.
`define RCM_ASSERT_HOLDS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("rcm invariant violated");

// The second condition holds in the cycle after the first.
`define RCM_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("rcm sequence violated");

`endif

FILE: rtl/rcm_pkg.sv
// Types and constants of the reverse Cuthill-McKee ordering core.
`timescale 1ns / 1ps
`default_nettype none
package rcm_pkg;

  localparam int NODE_FW  = 10;
  localparam int POS_FW   = 14;
  localparam int VAL_FW   = 14;
  localparam int SIZE_FW  = 11;
  localparam int DEG_W    = 14;
  localparam logic [DEG_W-1:0] DEG_MAX = 14'd16383;

  typedef enum logic [2:0] {
    OP_LOAD_ROW  = 3'd0,
    OP_LOAD_NB   = 3'd1,
    OP_LOAD_MASK = 3'd2,
    OP_RUN       = 3'd3,
    OP_READ      = 3'd4
  } rcm_op_t;

  localparam logic KIND_RUN  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef struct packed {
    logic [2:0]         operation;
    logic [POS_FW-1:0]  position;
    logic [VAL_FW-1:0]  value;
    logic [NODE_FW-1:0] root;
  } rcm_in_t;

  typedef struct packed {
    logic               kind;
    logic [SIZE_FW-1:0] component_size;
    logic [NODE_FW-1:0] node;
    logic               node_mask;
  } rcm_out_t;

endpackage
`default_nettype wire

FILE: rtl/rcm_stream_if.sv
// Valid/ready item channel with a typed payload.
`timescale 1ns / 1ps
`default_nettype none
interface rcm_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/rcm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module rcm_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: rtl/reverse_cuthill_mckee_order_core.sv
// Reverse Cuthill-McKee ordering core: graph tables, sequencer and result register.
//
// Channels: cmd (sink) carries operation, position, value and root; res (source)
// carries kind, component_size, node and node_mask. An item moves when valid and
// ready are both high.
// Load items (row start, neighbor entry, mask bit) are written in the cycle they
// are accepted, one per cycle while the sequencer is idle, and give no result.
// Codes 5 to 7 are taken and dropped. A read item goes through the ordering
// memory, then the mask memory, then the result register (a position past the
// table skips both). A run item clears the visited table, walks the component
// in a discovery pass and, for more than one node, a numbering pass that sorts
// each new group by insertion, then reverses the order pair by pair (a root past
// the table gives size 0 with no walk). Each step uses the single read port of
// each memory. Reset clears the mask and visited memories; cmd.ready stays low
// until that pass ends. Other tables are undefined until written.
// While the receiver stalls, a finished result waits in the output register;
// load items are still taken, and the next run or read result waits in its final
// state until the output register frees up.
`timescale 1ns / 1ps
`default_nettype none
`include "reverse_cuthill_mckee_order_core_macros.svh"
module reverse_cuthill_mckee_order_core #(
  parameter int MAX_NODES = 1024,
  parameter int MAX_EDGES = 8192
) (
  input wire logic clk,
  input wire logic rst,
  rcm_stream_if.sink   cmd,
  rcm_stream_if.source res
);
  import rcm_pkg::*;

  localparam int NODE_W = $clog2(MAX_NODES);
  localparam int RS_W   = $clog2(MAX_NODES + 1);
  localparam int EDGE_W = $clog2(MAX_EDGES);
  localparam int CNT_W  = $clog2(MAX_NODES + 1);

  typedef enum logic [28:0] {
    ST_INIT     = 29'h1 << 0,
    ST_IDLE     = 29'h1 << 1,
    ST_SEEN_CLR = 29'h1 << 2,
    ST_D_INIT   = 29'h1 << 3,
    ST_D_HEAD   = 29'h1 << 4,
    ST_NODE     = 29'h1 << 5,
    ST_RS0      = 29'h1 << 6,
    ST_RS1      = 29'h1 << 7,
    ST_EDGE     = 29'h1 << 8,
    ST_NB       = 29'h1 << 9,
    ST_D_CHK    = 29'h1 << 10,
    ST_N_START  = 29'h1 << 11,
    ST_N_LVL    = 29'h1 << 12,
    ST_N_ITEM   = 29'h1 << 13,
    ST_N_CHK    = 29'h1 << 14,
    ST_S_K      = 29'h1 << 15,
    ST_S_V      = 29'h1 << 16,
    ST_S_DV     = 29'h1 << 17,
    ST_S_L      = 29'h1 << 18,
    ST_S_U      = 29'h1 << 19,
    ST_S_CMP    = 29'h1 << 20,
    ST_R_LOOP   = 29'h1 << 21,
    ST_R_A      = 29'h1 << 22,
    ST_R_B      = 29'h1 << 23,
    ST_R_C      = 29'h1 << 24,
    ST_Q_ISSUE  = 29'h1 << 25,
    ST_Q_ORD    = 29'h1 << 26,
    ST_Q_MASK   = 29'h1 << 27,
    ST_DONE     = 29'h1 << 28
  } state_t;

  state_t state;

  // sequencer registers
  logic              phase;      // 0: discovery pass, 1: numbering pass
  logic [NODE_W-1:0] clr;
  logic [NODE_FW-1:0] root;
  logic [POS_FW-1:0] pos;
  logic [CNT_W-1:0]  head, cnt, placed, lvlend, i, k, l, grp, ri;
  logic [NODE_FW-1:0] n, nb, v, u, t;
  logic [VAL_FW-1:0] a, b, j;
  logic [DEG_W-1:0]  d, dv;
  logic [SIZE_FW-1:0] size_count;
  rcm_out_t          res_reg;
  rcm_out_t          out_reg;
  logic              out_valid;

  // memory ports
  logic              rs_we;   logic [RS_W-1:0]   rs_waddr, rs_raddr;
  logic [VAL_FW-1:0] rs_wdata, rs_rdata;
  logic              nbm_we;  logic [EDGE_W-1:0] nbm_waddr, nbm_raddr;
  logic [NODE_FW-1:0] nbm_wdata, nbm_rdata;
  logic              msk_we;  logic [NODE_W-1:0] msk_waddr, msk_raddr;
  logic              msk_wdata, msk_rdata;
  logic              seen_we; logic [NODE_W-1:0] seen_waddr, seen_raddr;
  logic              seen_wdata, seen_rdata;
  logic              deg_we;  logic [NODE_W-1:0] deg_waddr, deg_raddr;
  logic [DEG_W-1:0]  deg_wdata, deg_rdata;
  logic              ord_we;  logic [NODE_W-1:0] ord_waddr, ord_raddr;
  logic [NODE_FW-1:0] ord_wdata, ord_rdata;

  rcm_ram #(.WIDTH(VAL_FW),  .DEPTH(MAX_NODES + 1)) u_row_start (
    .clk, .we(rs_we), .waddr(rs_waddr), .wdata(rs_wdata), .raddr(rs_raddr), .rdata(rs_rdata));
  rcm_ram #(.WIDTH(NODE_FW), .DEPTH(MAX_EDGES)) u_neighbor (
    .clk, .we(nbm_we), .waddr(nbm_waddr), .wdata(nbm_wdata), .raddr(nbm_raddr),
    .rdata(nbm_rdata));
  rcm_ram #(.WIDTH(1),       .DEPTH(MAX_NODES)) u_mask (
    .clk, .we(msk_we), .waddr(msk_waddr), .wdata(msk_wdata), .raddr(msk_raddr),
    .rdata(msk_rdata));
  rcm_ram #(.WIDTH(1),       .DEPTH(MAX_NODES)) u_seen (
    .clk, .we(seen_we), .waddr(seen_waddr), .wdata(seen_wdata), .raddr(seen_raddr),
    .rdata(seen_rdata));
  rcm_ram #(.WIDTH(DEG_W),   .DEPTH(MAX_NODES)) u_degree (
    .clk, .we(deg_we), .waddr(deg_waddr), .wdata(deg_wdata), .raddr(deg_raddr),
    .rdata(deg_rdata));
  rcm_ram #(.WIDTH(NODE_FW), .DEPTH(MAX_NODES)) u_ordering (
    .clk, .we(ord_we), .waddr(ord_waddr), .wdata(ord_wdata), .raddr(ord_raddr),
    .rdata(ord_rdata));

  logic accept;
  logic clr_last;
  logic nb_ok;
  logic [VAL_FW-1:0] b_clamp, a_clamp;
  logic [CNT_W-1:0]  rev_hi;
  logic d_add, n_add;

  assign accept   = cmd.valid && cmd.ready;
  assign clr_last = (clr == NODE_W'(MAX_NODES - 1));
  assign nb_ok    = (32'(nb) < MAX_NODES);
  // edge range: end clamped to the neighbor table, inverted rows become empty
  assign b_clamp  = (32'(rs_rdata) > MAX_EDGES) ? VAL_FW'(MAX_EDGES) : rs_rdata;
  assign a_clamp  = (a > b_clamp) ? b_clamp : a;
  assign rev_hi   = cnt - CNT_W'(1) - ri;
  assign d_add    = nb_ok && msk_rdata && !seen_rdata && (32'(cnt) < MAX_NODES);
  assign n_add    = nb_ok && msk_rdata && (32'(placed) < MAX_NODES);

  assign cmd.ready = (state == ST_IDLE);
  assign res.valid = out_valid;
  assign res.data  = out_reg;

  // memory address and write control per sequencer state
  always_comb begin
    rs_we = 1'b0;  rs_waddr = '0;  rs_wdata = '0;  rs_raddr = '0;
    nbm_we = 1'b0; nbm_waddr = '0; nbm_wdata = '0; nbm_raddr = '0;
    msk_we = 1'b0; msk_waddr = '0; msk_wdata = 1'b0; msk_raddr = '0;
    seen_we = 1'b0; seen_waddr = '0; seen_wdata = 1'b0; seen_raddr = '0;
    deg_we = 1'b0; deg_waddr = '0; deg_wdata = '0; deg_raddr = '0;
    ord_we = 1'b0; ord_waddr = '0; ord_wdata = '0; ord_raddr = '0;
    case (state)
      ST_INIT: begin
        msk_we = 1'b1;  msk_waddr = clr;
        seen_we = 1'b1; seen_waddr = clr;
      end
      ST_IDLE: begin
        if (accept) begin
          case (cmd.data.operation)
            OP_LOAD_ROW: begin
              rs_we    = (32'(cmd.data.position) <= MAX_NODES);
              rs_waddr = RS_W'(cmd.data.position);
              rs_wdata = cmd.data.value;
            end
            OP_LOAD_NB: begin
              nbm_we    = (32'(cmd.data.position) < MAX_EDGES);
              nbm_waddr = EDGE_W'(cmd.data.position);
              nbm_wdata = cmd.data.value[NODE_FW-1:0];
            end
            OP_LOAD_MASK: begin
              msk_we    = (32'(cmd.data.position) < MAX_NODES);
              msk_waddr = NODE_W'(cmd.data.position);
              msk_wdata = cmd.data.value[0];
            end
            default: ;
          endcase
        end
      end
      ST_SEEN_CLR: begin
        seen_we = 1'b1; seen_waddr = clr;
      end
      ST_D_INIT: begin
        seen_we = 1'b1; seen_waddr = NODE_W'(root); seen_wdata = 1'b1;
        ord_we  = 1'b1; ord_waddr  = '0;            ord_wdata  = root;
      end
      ST_D_HEAD:  ord_raddr = NODE_W'(head);
      ST_NODE:    rs_raddr  = RS_W'(ord_rdata);
      ST_RS0:     rs_raddr  = RS_W'(n) + RS_W'(1);
      ST_EDGE: begin
        if (j < b) begin
          nbm_raddr = EDGE_W'(j);
        end else if (!phase) begin
          deg_we = 1'b1; deg_waddr = NODE_W'(n); deg_wdata = d;
        end
      end
      ST_NB: begin
        msk_raddr  = NODE_W'(nbm_rdata);
        seen_raddr = NODE_W'(nbm_rdata);
      end
      ST_D_CHK: begin
        if (d_add) begin
          seen_we = 1'b1; seen_waddr = NODE_W'(nb); seen_wdata = 1'b1;
          ord_we  = 1'b1; ord_waddr  = NODE_W'(cnt); ord_wdata = nb;
        end
      end
      ST_N_START: begin
        msk_we = 1'b1; msk_waddr = NODE_W'(root);
      end
      ST_N_ITEM:  ord_raddr = NODE_W'(i);
      ST_N_CHK: begin
        if (n_add) begin
          msk_we = 1'b1; msk_waddr = NODE_W'(nb);
          ord_we = 1'b1; ord_waddr = NODE_W'(placed); ord_wdata = nb;
        end
      end
      ST_S_K:     ord_raddr = NODE_W'(k);
      ST_S_V:     deg_raddr = NODE_W'(ord_rdata);
      ST_S_L: begin
        if (l > grp) begin
          ord_raddr = NODE_W'(l - CNT_W'(1));
        end else begin
          ord_we = 1'b1; ord_waddr = NODE_W'(l); ord_wdata = v;
        end
      end
      ST_S_U:     deg_raddr = NODE_W'(ord_rdata);
      ST_S_CMP: begin
        ord_we = 1'b1; ord_waddr = NODE_W'(l);
        ord_wdata = (deg_rdata > dv) ? u : v;
      end
      ST_R_LOOP:  ord_raddr = NODE_W'(ri);
      ST_R_A:     ord_raddr = NODE_W'(rev_hi);
      ST_R_B: begin
        ord_we = 1'b1; ord_waddr = NODE_W'(ri); ord_wdata = ord_rdata;
      end
      ST_R_C: begin
        ord_we = 1'b1; ord_waddr = NODE_W'(rev_hi); ord_wdata = t;
      end
      ST_Q_ISSUE: ord_raddr = NODE_W'(pos);
      ST_Q_ORD:   msk_raddr = NODE_W'(ord_rdata);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_INIT;
      clr        <= '0;
      out_valid  <= 1'b0;
      size_count <= '0;
      phase      <= 1'b0;
      head       <= '0;
      cnt        <= '0;
      placed     <= '0;
      lvlend     <= '0;
      i          <= '0;
    end else begin
      if (res.valid && res.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_INIT: begin
          clr <= clr + NODE_W'(1);
          if (clr_last) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            case (cmd.data.operation)
              OP_RUN: begin
                root <= cmd.data.root;
                if (32'(cmd.data.root) >= MAX_NODES) begin
                  size_count <= '0;
                  res_reg    <= '{kind: KIND_RUN, component_size: '0, node: '0,
                                  node_mask: 1'b0};
                  state      <= ST_DONE;
                end else begin
                  clr   <= '0;
                  state <= ST_SEEN_CLR;
                end
              end
              OP_READ: begin
                pos <= cmd.data.position;
                if (32'(cmd.data.position) < MAX_NODES) begin
                  state <= ST_Q_ISSUE;
                end else begin
                  res_reg <= '{kind: KIND_READ, component_size: size_count, node: '0,
                               node_mask: 1'b0};
                  state   <= ST_DONE;
                end
              end
              default: ;
            endcase
          end
        end
        ST_SEEN_CLR: begin
          clr <= clr + NODE_W'(1);
          if (clr_last) begin
            state <= ST_D_INIT;
          end
        end
        ST_D_INIT: begin
          head  <= '0;
          cnt   <= CNT_W'(1);
          phase <= 1'b0;
          state <= ST_D_HEAD;
        end
        ST_D_HEAD: begin
          state <= (head < cnt) ? ST_NODE : ST_N_START;
        end
        ST_NODE: begin
          n     <= ord_rdata;
          grp   <= placed;
          state <= ST_RS0;
        end
        ST_RS0: begin
          a     <= rs_rdata;
          state <= ST_RS1;
        end
        ST_RS1: begin
          a     <= a_clamp;
          b     <= b_clamp;
          j     <= a_clamp;
          d     <= '0;
          state <= ST_EDGE;
        end
        ST_EDGE: begin
          if (j < b) begin
            state <= ST_NB;
          end else if (!phase) begin
            head  <= head + CNT_W'(1);
            state <= ST_D_HEAD;
          end else begin
            k     <= grp + CNT_W'(1);
            state <= ST_S_K;
          end
        end
        ST_NB: begin
          nb    <= nbm_rdata;
          state <= phase ? ST_N_CHK : ST_D_CHK;
        end
        ST_D_CHK: begin
          // degree counts every masked neighbor; only unseen ones join the queue
          if (nb_ok && msk_rdata && (d != DEG_MAX)) begin
            d <= d + DEG_W'(1);
          end
          if (d_add) begin
            cnt <= cnt + CNT_W'(1);
          end
          j     <= j + VAL_FW'(1);
          state <= ST_EDGE;
        end
        ST_N_START: begin
          size_count <= SIZE_FW'(cnt);
          if (cnt <= CNT_W'(1)) begin
            res_reg <= '{kind: KIND_RUN, component_size: SIZE_FW'(cnt), node: '0,
                         node_mask: 1'b0};
            state   <= ST_DONE;
          end else begin
            lvlend <= '0;
            placed <= CNT_W'(1);
            phase  <= 1'b1;
            state  <= ST_N_LVL;
          end
        end
        ST_N_LVL: begin
          if (placed > lvlend) begin
            i      <= lvlend;
            lvlend <= placed;
            state  <= ST_N_ITEM;
          end else begin
            ri    <= '0;
            state <= ST_R_LOOP;
          end
        end
        ST_N_ITEM: begin
          state <= (i < lvlend) ? ST_NODE : ST_N_LVL;
        end
        ST_N_CHK: begin
          if (n_add) begin
            placed <= placed + CNT_W'(1);
          end
          j     <= j + VAL_FW'(1);
          state <= ST_EDGE;
        end
        // stable insertion sort of the new group by rising degree
        ST_S_K: begin
          if (k < placed) begin
            state <= ST_S_V;
          end else begin
            i     <= i + CNT_W'(1);
            state <= ST_N_ITEM;
          end
        end
        ST_S_V: begin
          v     <= ord_rdata;
          l     <= k;
          state <= ST_S_DV;
        end
        ST_S_DV: begin
          dv    <= deg_rdata;
          state <= ST_S_L;
        end
        ST_S_L: begin
          if (l > grp) begin
            state <= ST_S_U;
          end else begin
            k     <= k + CNT_W'(1);
            state <= ST_S_K;
          end
        end
        ST_S_U: begin
          u     <= ord_rdata;
          state <= ST_S_CMP;
        end
        ST_S_CMP: begin
          if (deg_rdata > dv) begin
            l     <= l - CNT_W'(1);
            state <= ST_S_L;
          end else begin
            k     <= k + CNT_W'(1);
            state <= ST_S_K;
          end
        end
        // in-place reversal, one pair at a time
        ST_R_LOOP: begin
          if (ri < (cnt >> 1)) begin
            state <= ST_R_A;
          end else begin
            res_reg <= '{kind: KIND_RUN, component_size: SIZE_FW'(cnt), node: '0,
                         node_mask: 1'b0};
            state   <= ST_DONE;
          end
        end
        ST_R_A: begin
          t     <= ord_rdata;
          state <= ST_R_B;
        end
        ST_R_B: state <= ST_R_C;
        ST_R_C: begin
          ri    <= ri + CNT_W'(1);
          state <= ST_R_LOOP;
        end
        ST_Q_ISSUE: state <= ST_Q_ORD;
        ST_Q_ORD: begin
          n     <= ord_rdata;
          state <= ST_Q_MASK;
        end
        ST_Q_MASK: begin
          res_reg <= '{kind: KIND_READ, component_size: size_count, node: n,
                       node_mask: (32'(n) < MAX_NODES) ? msk_rdata : 1'b0};
          state   <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid || res.ready) begin
            out_reg   <= res_reg;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_INIT;
      endcase
    end
  end

  `RCM_ASSERT_HOLDS(a_placed_bound, clk, rst, 32'(placed) <= MAX_NODES)
  `RCM_ASSERT_HOLDS(a_level_order, clk, rst, (state != ST_N_ITEM) || ((i <= lvlend) && (lvlend <= placed)))
  `RCM_ASSERT_HOLDS(a_queue_live, clk, rst, (state != ST_D_HEAD) || (cnt != '0))
  `RCM_ASSERT_NEXT(a_result_held, clk, rst, (state == ST_DONE) && out_valid && !res.ready, state == ST_DONE)

endmodule
`default_nettype wire

FILE: dv/rcm_order_checker.sv
// Channel monitor, ordering predictor and result comparator for the ordering core.
`timescale 1ns / 1ps
module rcm_order_checker
  import rcm_pkg::*;
#(
  parameter int MAX_NODES = 1024,
  parameter int MAX_EDGES = 8192
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     cmd_valid,
  input  logic     cmd_ready,
  input  rcm_in_t  cmd_data,
  input  logic     res_valid,
  input  logic     res_ready,
  input  rcm_out_t res_data,
  output int       fail_count,
  output int       order_depth,
  output int       outstanding
);

  logic [VAL_FW-1:0]  row_tab [0:MAX_NODES];
  logic [NODE_FW-1:0] nbr_tab [0:MAX_EDGES-1];
  bit                 mask_tab[0:MAX_NODES-1];
  int                 deg_tab [0:MAX_NODES-1];
  logic [NODE_FW-1:0] order_tab[0:MAX_NODES-1];
  int                 comp_size;
  rcm_out_t           expected_q[$];

  assign outstanding = expected_q.size();

  // neighbor slice of node n, clamped and with inverted rows made empty
  task automatic edge_span(input int n, output int a, output int b);
    a = row_tab[n];
    b = row_tab[n + 1];
    if (b > MAX_EDGES) b = MAX_EDGES;
    if (a > b) a = b;
  endtask

  task automatic order_component(input int r);
    int head, cnt, a, b, j, n, nb, d, lbeg, lend, placed, grp, k, l, v, t, i;
    bit seen[0:MAX_NODES-1];
    for (i = 0; i < MAX_NODES; i++) seen[i] = 0;
    // pass 1: component discovery, degrees count masked neighbors only
    order_tab[0] = NODE_FW'(r);
    seen[r] = 1;
    head = 0;
    cnt = 1;
    while (head < cnt) begin
      n = order_tab[head];
      head++;
      d = 0;
      edge_span(n, a, b);
      for (j = a; j < b; j++) begin
        nb = nbr_tab[j];
        if (nb >= MAX_NODES || !mask_tab[nb]) continue;
        if (d < DEG_MAX) d++;
        if (seen[nb] || cnt >= MAX_NODES) continue;
        seen[nb] = 1;
        order_tab[cnt] = NODE_FW'(nb);
        cnt++;
      end
      deg_tab[n] = d;
    end
    comp_size = cnt;
    mask_tab[r] = 0;
    if (cnt > order_depth) order_depth = cnt;
    if (cnt <= 1) return;
    // pass 2: level numbering, each new group stably sorted by degree
    lend = 0;
    placed = 1;
    while (placed > lend) begin
      lbeg = lend;
      lend = placed;
      for (i = lbeg; i < lend; i++) begin
        n = order_tab[i];
        grp = placed;
        edge_span(n, a, b);
        for (j = a; j < b; j++) begin
          nb = nbr_tab[j];
          if (nb >= MAX_NODES || !mask_tab[nb] || placed >= MAX_NODES) continue;
          mask_tab[nb] = 0;
          order_tab[placed] = NODE_FW'(nb);
          placed++;
        end
        for (k = grp + 1; k < placed; k++) begin
          v = order_tab[k];
          l = k;
          while (l > grp && deg_tab[order_tab[l - 1]] > deg_tab[v]) begin
            order_tab[l] = order_tab[l - 1];
            l--;
          end
          order_tab[l] = NODE_FW'(v);
        end
      end
    end
    for (i = 0; i < cnt / 2; i++) begin
      t = order_tab[i];
      order_tab[i] = order_tab[cnt - 1 - i];
      order_tab[cnt - 1 - i] = NODE_FW'(t);
    end
  endtask

  task automatic predict(input rcm_in_t it);
    rcm_out_t r;
    int n;
    r = '0;
    case (it.operation)
      OP_LOAD_ROW:  if (it.position <= MAX_NODES) row_tab[it.position] = it.value;
      OP_LOAD_NB:   if (it.position < MAX_EDGES) nbr_tab[it.position] = it.value[NODE_FW-1:0];
      OP_LOAD_MASK: if (it.position < MAX_NODES) mask_tab[it.position] = it.value[0];
      OP_RUN: begin
        if (it.root < MAX_NODES) order_component(it.root);
        else comp_size = 0;
        r.kind = KIND_RUN;
        r.component_size = SIZE_FW'(comp_size);
        expected_q.push_back(r);
      end
      OP_READ: begin
        r.kind = KIND_READ;
        r.component_size = SIZE_FW'(comp_size);
        if (it.position < MAX_NODES) begin
          n = order_tab[it.position];
          r.node = NODE_FW'(n);
          r.node_mask = mask_tab[n];
        end
        expected_q.push_back(r);
      end
      default: ;
    endcase
  endtask

  initial begin
    fail_count = 0;
    order_depth = 0;
    comp_size = 0;
    for (int i = 0; i < MAX_NODES; i++) mask_tab[i] = 0;
  end

  always @(posedge clk) begin
    rcm_out_t want;
    if (!rst) begin
      if (cmd_valid && cmd_ready) predict(cmd_data);
      if (res_valid && res_ready) begin
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result item %p", res_data);
        end else begin
          want = expected_q.pop_front();
          if (res_data.kind !== want.kind
              || res_data.component_size !== want.component_size
              || res_data.node !== want.node
              || res_data.node_mask !== want.node_mask) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected kind %0d size %0d node %0d mask %0d, got %0d %0d %0d %0d",
                       want.kind, want.component_size, want.node, want.node_mask,
                       res_data.kind, res_data.component_size, res_data.node,
                       res_data.node_mask);
          end
        end
      end
    end
  end

endmodule

FILE: dv/tb_reverse_cuthill_mckee_order_core.sv
// Stimulus, clock, reset and verdict for the ordering core testbench.
`timescale 1ns / 1ps
module tb_reverse_cuthill_mckee_order_core;
  import rcm_pkg::*;

  // Graph lives in a small pool: nodes 0..31 carry masks, their row starts
  // point into neighbor slots 0..63, which are all written up front. That
  // keeps every run away from table entries that were never loaded.
  localparam int NODE_POOL = 32;
  localparam int EDGE_POOL = 64;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count, order_depth, outstanding;
  bit   calm = 0;      // no idling in the closing stretch
  bit   hold_req = 0;  // receiver long hold-off request

  rcm_stream_if #(.T(rcm_in_t))  cmd ();
  rcm_stream_if #(.T(rcm_out_t)) res ();

  reverse_cuthill_mckee_order_core dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .res (res)
  );

  rcm_order_checker chk (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd.valid),
    .cmd_ready   (cmd.ready),
    .cmd_data    (cmd.data),
    .res_valid   (res.valid),
    .res_ready   (res.ready),
    .res_data    (res.data),
    .fail_count  (fail_count),
    .order_depth (order_depth),
    .outstanding (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offer one item from a falling edge; hold it until the handshake.
  // Valid stays high between back-to-back items.
  task automatic send(input logic [2:0] op, input int pos, input int val, input int rt);
    if (!calm && $urandom_range(0, 7) == 0) begin
      cmd.valid = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    cmd.data.operation = op;
    cmd.data.position  = POS_FW'(pos);
    cmd.data.value     = VAL_FW'(val);
    cmd.data.root      = NODE_FW'(rt);
    cmd.valid = 1'b1;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Read a defined order slot, or now and then one past the table.
  task automatic read_slot();
    int pos;
    if (order_depth == 0 || $urandom_range(0, 7) == 0) pos = $urandom_range(1024, 16383);
    else pos = $urandom_range(0, order_depth - 1);
    send(OP_READ, pos, $urandom_range(0, 16383), $urandom_range(0, 1023));
  endtask

  // Receiver: ready decided at falling edges, random stall bursts,
  // one long hold-off on request so the block backs up into its input.
  initial begin
    res.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        res.ready = 1'b0;
        repeat (300) @(negedge clk);
        hold_req = 0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        res.ready = 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk);
      end else begin
        res.ready = 1'b1;
        @(negedge clk);
      end
    end
  end

  initial begin
    int v, nrows, s, step;
    cmd.valid = 1'b0;
    cmd.data  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // pool setup: neighbor slots and row starts for all pool nodes
    for (int i = 0; i < EDGE_POOL; i++) send(OP_LOAD_NB, i, $urandom_range(0, NODE_POOL - 1), 0);
    v = 0;
    for (int i = 0; i <= NODE_POOL; i++) begin
      send(OP_LOAD_ROW, i, v, 0);
      step = $urandom_range(0, 3);
      v = (v + step > EDGE_POOL) ? EDGE_POOL : v + step;
    end

    // directed part
    send(OP_RUN, 0, 0, 5);                   // single node: nothing masked, root unmasked
    read_slot();
    send(OP_READ, 16383, 16383, 1023);       // read past the order table
    // top node with a clamped row that runs off the end of the neighbor table
    send(OP_LOAD_ROW, 1023, 8190, 0);
    send(OP_LOAD_ROW, 1024, 16383, 0);
    send(OP_LOAD_NB, 8190, 16383, 0);        // low bits give node 1023: self loop
    send(OP_LOAD_NB, 8191, 3, 0);
    send(OP_LOAD_NB, 16383, 7, 0);           // out of range, ignored
    send(OP_LOAD_ROW, 1025, 5, 0);           // out of range, ignored
    send(OP_LOAD_MASK, 1024, 1, 0);          // out of range, ignored
    send(OP_LOAD_MASK, 3, 1, 0);
    send(OP_LOAD_MASK, 4, 2, 0);             // only bit 0 counts
    send(OP_LOAD_MASK, 1023, 1, 0);
    for (int i = 5; i < 12; i++) send(OP_LOAD_MASK, i, 1, 0);
    send(OP_RUN, 0, 0, 1023);
    read_slot();
    read_slot();
    send(5, 1, 1, 1);                        // unused codes
    send(6, 16383, 0, 0);
    send(7, 0, 16383, 1023);

    // random phases: rewrite part of the graph, mask a set, run, read back
    for (int ph = 0; ph < 12; ph++) begin
      if (ph >= 10) calm = 1;
      nrows = $urandom_range(2, 10);
      s = $urandom_range(0, NODE_POOL);
      v = $urandom_range(0, EDGE_POOL);
      for (int k = 0; k < nrows && s + k <= NODE_POOL; k++) begin
        // mostly rising offsets, some arbitrary ones for empty or inverted rows
        if ($urandom_range(0, 3) == 0) v = $urandom_range(0, EDGE_POOL);
        else begin
          step = $urandom_range(0, 4);
          v = (v + step > EDGE_POOL) ? EDGE_POOL : v + step;
        end
        send(OP_LOAD_ROW, s + k, v, 0);
      end
      repeat ($urandom_range(4, 12)) begin
        if ($urandom_range(0, 7) == 0) v = $urandom_range(0, 16383);
        else v = $urandom_range(0, NODE_POOL - 1);
        send(OP_LOAD_NB, $urandom_range(0, EDGE_POOL - 1), v, 0);
      end
      repeat ($urandom_range(8, 20)) begin
        v = ($urandom_range(0, 8191) << 1) | ($urandom_range(0, 3) != 0);
        send(OP_LOAD_MASK, $urandom_range(0, NODE_POOL - 1), v, 0);
      end
      if (ph == 3) hold_req = 1;
      repeat (3) begin
        send(OP_RUN, $urandom_range(0, 16383), $urandom_range(0, 16383),
             $urandom_range(0, NODE_POOL - 1));
        repeat ($urandom_range(3, 6)) read_slot();
      end
      if ($urandom_range(0, 1)) send($urandom_range(5, 7), $urandom_range(0, 16383),
                                     $urandom_range(0, 16383), $urandom_range(0, 1023));
    end
    cmd.valid = 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS reverse_cuthill_mckee_order_core");
    end else begin
      $display("FAIL reverse_cuthill_mckee_order_core");
    end
    $finish;
  end

  // Runs clear a 1024-entry table each, so the watchdog allows a long run time.
  initial begin
    #20_000_000;
    $display("FAIL reverse_cuthill_mckee_order_core");
    $finish;
  end

endmodule
